/* hw/rtl/okvt_pkg.sv */
// ============================================================================
// okvt_pkg
// Shared types and constants for the ordered key/value table.
// ============================================================================
package okvt_pkg;

	localparam int CAPACITY    = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;

	localparam int REQ_WIDTH   = 3;
	localparam int INDEX_WIDTH = 4;
	localparam int COUNT_WIDTH = 5;   // width of the entry_count field

	// internal count, wide enough to hold CAPACITY itself
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// width used to compare a request index against count and cell positions
	localparam int CMP_W = (CNT_W > INDEX_WIDTH) ? CNT_W : INDEX_WIDTH;

	typedef enum logic [REQ_WIDTH-1:0] {
		REQ_INSERT     = 3'd0,
		REQ_UPDATE     = 3'd1,
		REQ_INS_UPD    = 3'd2,
		REQ_ERASE      = 3'd3,
		REQ_CONTAINS   = 3'd4,
		REQ_GET_KEY    = 3'd5,
		REQ_GET_INDEX  = 3'd6,
		REQ_RESERVED   = 3'd7
	} okvt_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} okvt_state_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic                   cmp;        // latch a fresh match flag
		logic [KEY_WIDTH-1:0]   cmp_key;
		logic                   apply;      // commit the request this cycle
		logic                   insert;     // tail cell loads key/value
		logic                   set_value;  // matching cell takes new value
		logic                   erase;      // cells at or after the match shift down
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} okvt_cell_ctl_t;

endpackage

/* hw/rtl/okvt_req_if.sv */
// ============================================================================
// okvt_req_if
// Request channel: valid/ready handshake with the request payload.
// ============================================================================
interface okvt_req_if;
	import okvt_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [REQ_WIDTH-1:0]   req_type;
	logic [KEY_WIDTH-1:0]   key;
	logic [VALUE_WIDTH-1:0] value;
	logic [INDEX_WIDTH-1:0] index;

	modport source (output valid, req_type, key, value, index, input ready);
	modport sink   (input valid, req_type, key, value, index, output ready);

endinterface

/* hw/rtl/okvt_rsp_if.sv */
// ============================================================================
// okvt_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ============================================================================
interface okvt_rsp_if;
	import okvt_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   ok;
	logic [KEY_WIDTH-1:0]   found_key;
	logic [VALUE_WIDTH-1:0] found_value;
	logic [COUNT_WIDTH-1:0] entry_count;

	modport source (output valid, ok, found_key, found_value, entry_count, input ready);
	modport sink   (input valid, ok, found_key, found_value, entry_count, output ready);

endinterface

/* hw/rtl/okvt_cell.sv */
// ============================================================================
// okvt_cell
// One table slot: holds a key/value pair, compares against the broadcast key,
// and loads, updates or takes its right neighbor's pair on commit.
// ============================================================================
module okvt_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  okvt_pkg::okvt_cell_ctl_t            ctl,
	input  logic                                occupied,  // position < count
	input  logic                                tail,      // position == count
	input  logic                                seen_in,   // match left of here
	input  logic [okvt_pkg::KEY_WIDTH-1:0]      nbr_key,
	input  logic [okvt_pkg::VALUE_WIDTH-1:0]    nbr_value,
	output logic                                seen_out,
	output logic                                match,
	output logic [okvt_pkg::KEY_WIDTH-1:0]      key,
	output logic [okvt_pkg::VALUE_WIDTH-1:0]    value
);
	import okvt_pkg::*;

	logic                   match_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= occupied && (key_q == ctl.cmp_key);
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			if (ctl.insert && tail) begin
				key_q   <= ctl.key;
				value_q <= ctl.value;
			end else if (ctl.set_value && match_q) begin
				value_q <= ctl.value;
			end else if (ctl.erase && (seen_in || match_q)) begin
				key_q   <= nbr_key;
				value_q <= nbr_value;
			end
		end
	end

	assign seen_out = seen_in || match_q;
	assign match    = match_q;
	assign key      = key_q;
	assign value    = value_q;

endmodule

/* hw/rtl/ordered_key_value_table.sv */
// ============================================================================
// ordered_key_value_table
// Bounded key/value table in insertion order, built as a row of slot cells.
// ============================================================================
// Usage:
//   req  (sink)  : one request per handshake: req_type, key, value, index.
//   rsp  (source): one result per request: ok, found_key, found_value,
//                  entry_count (entries after the request).
// Operation:
//   - On accept every cell compares its key with the request key in
//     parallel and registers a match flag.
//   - Once the output register is free the control commits: the tail cell
//     loads an insert, the matching cell takes an update, and on erase every
//     cell at or after the match takes its right neighbor's pair (order kept).
// Flow:
//   - Each request takes a compare step and then a commit step; the result
//     is registered in the output register on commit.
//   - One request in flight; a new request is taken while an earlier result
//     still sits in the output register.
// Stall: if rsp is not taken, commit waits until the output register frees.
// Reset: the entry count clears to zero; slot contents are left as they are
//   and only occupied slots are ever read.
// ============================================================================
module ordered_key_value_table (
	input  logic        clk,
	input  logic        arst_n,
	okvt_req_if.sink    req,
	okvt_rsp_if.source  rsp
);
	import okvt_pkg::*;

	okvt_state_t state_q, state_d;

	// request held for the commit cycle
	okvt_req_t              req_type_s1;
	logic [KEY_WIDTH-1:0]   key_s1;
	logic [VALUE_WIDTH-1:0] value_s1;
	logic [INDEX_WIDTH-1:0] index_s1;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	// result register
	logic                   rsp_valid_q;
	logic                   rsp_ok_q;
	logic [KEY_WIDTH-1:0]   rsp_key_q;
	logic [VALUE_WIDTH-1:0] rsp_value_q;
	logic [COUNT_WIDTH-1:0] rsp_count_q;

	logic accept;
	logic apply_go;

	okvt_cell_ctl_t         ctl;
	logic [CAPACITY-1:0]    match;
	logic [CAPACITY:0]      seen;
	logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
	logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];

	logic                   hit;
	logic                   full;
	logic                   idx_ok;
	logic [VALUE_WIDTH-1:0] hit_value;
	logic [KEY_WIDTH-1:0]   idx_key;
	logic [VALUE_WIDTH-1:0] idx_value;

	logic                   res_ok;
	logic [KEY_WIDTH-1:0]   res_key;
	logic [VALUE_WIDTH-1:0] res_value;
	logic                   do_insert;
	logic                   do_set;
	logic                   do_erase;

	// ---------------- control FSM ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept)   state_d = ST_APPLY;
			ST_APPLY: if (apply_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		apply_go  = 1'b0;
		case (state_q)
			ST_IDLE:  req.ready = 1'b1;
			ST_APPLY: apply_go  = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				apply_go  = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= okvt_req_t'(req.req_type);
			key_s1      <= req.key;
			value_s1    <= req.value;
			index_s1    <= req.index;
		end
	end

	// ---------------- lookups over the match flags ----------------
	assign hit    = |match;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign idx_ok = (CMP_W'(index_s1) < CMP_W'(count_q));

	// keys are unique among occupied slots, so at most one flag is set
	always_comb begin
		hit_value = '0;
		idx_key   = '0;
		idx_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match[i]) hit_value = hit_value | cell_value[i];
			if (CMP_W'(i) == CMP_W'(index_s1)) begin
				idx_key   = cell_key[i];
				idx_value = cell_value[i];
			end
		end
	end

	// ---------------- request decode ----------------
	always_comb begin
		res_ok    = 1'b0;
		res_key   = key_s1;
		res_value = '0;
		do_insert = 1'b0;
		do_set    = 1'b0;
		do_erase  = 1'b0;
		count_d   = count_q;
		case (req_type_s1)
			REQ_INSERT: begin
				do_insert = !hit && !full;
				res_ok    = do_insert;
			end
			REQ_UPDATE: begin
				do_set = hit;
				res_ok = hit;
			end
			REQ_INS_UPD: begin
				do_set    = hit;
				do_insert = !hit && !full;
				res_ok    = do_set || do_insert;
			end
			REQ_ERASE: begin
				do_erase = hit;
				res_ok   = hit;
			end
			REQ_CONTAINS: begin
				res_ok = hit;
			end
			REQ_GET_KEY: begin
				res_ok    = hit;
				res_value = hit_value;
			end
			REQ_GET_INDEX: begin
				res_ok = idx_ok;
				if (idx_ok) begin
					res_key   = idx_key;
					res_value = idx_value;
				end
			end
			default: res_ok = 1'b0;   // reserved type: no-op
		endcase
		if (do_insert) count_d = count_q + CNT_W'(1);
		if (do_erase)  count_d = count_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_go) begin
			count_q <= count_d;
		end
	end

	// ---------------- cell row ----------------
	always_comb begin
		ctl.cmp       = accept;
		ctl.cmp_key   = req.key;
		ctl.apply     = apply_go;
		ctl.insert    = do_insert;
		ctl.set_value = do_set;
		ctl.erase     = do_erase;
		ctl.key       = key_s1;
		ctl.value     = value_s1;
	end

	assign seen[0] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_WIDTH-1:0]   nbr_key;
		logic [VALUE_WIDTH-1:0] nbr_value;

		// last slot has no right neighbor; what it takes on erase is unused
		if (g == CAPACITY - 1) begin : g_last
			assign nbr_key   = cell_key[g];
			assign nbr_value = cell_value[g];
		end else begin : g_mid
			assign nbr_key   = cell_key[g+1];
			assign nbr_value = cell_value[g+1];
		end

		okvt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.occupied  (count_q > CNT_W'(g)),
			.tail      (count_q == CNT_W'(g)),
			.seen_in   (seen[g]),
			.nbr_key   (nbr_key),
			.nbr_value (nbr_value),
			.seen_out  (seen[g+1]),
			.match     (match[g]),
			.key       (cell_key[g]),
			.value     (cell_value[g])
		);
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			rsp_ok_q    <= res_ok;
			rsp_key_q   <= res_key;
			rsp_value_q <= res_value;
			rsp_count_q <= COUNT_WIDTH'(count_d);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.found_key   = rsp_key_q;
	assign rsp.found_value = rsp_value_q;
	assign rsp.entry_count = rsp_count_q;

	// ---------------- assertions ----------------
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one slot matched the request key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_erase_count: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go && do_erase |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("erase did not drop the entry count");

	a_no_commit_over_result: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go |-> !rsp_valid_q || rsp.ready)
		else $error("commit would overwrite an untaken result");

endmodule
